[hw/rtl/pvm_pkg.sv]
// ----------------------------------------------------------------------------
// PCM voice mixer package
// Types, command codes and constants shared by the mixer controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package pvm_pkg;

  localparam int          SUM_W     = 17;
  localparam logic [16:0] MAX_LEN   = 17'h10000;
  localparam logic [7:0]  MIX_START = 8'd127;
  localparam logic [1:0]  NST_ONCE  = 2'd1;
  localparam logic [1:0]  NST_LOOP  = 2'd2;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_WRITE = 3'd1,
    OP_SLOT  = 3'd2,
    OP_ALLOC = 3'd3,
    OP_FREE  = 3'd4,
    OP_VSLOT = 3'd5,
    OP_STATE = 3'd6,
    OP_SEEK  = 3'd7
  } pvm_op_t;

  typedef enum logic [1:0] {
    MODE_UNUSED = 2'd0,
    MODE_PAUSED = 2'd1,
    MODE_ONCE   = 2'd2,
    MODE_LOOP   = 2'd3
  } pvm_mode_t;

  typedef enum logic [2:0] {
    VOP_NONE  = 3'd0,
    VOP_ALLOC = 3'd1,
    VOP_FREE  = 3'd2,
    VOP_SLOT  = 3'd3,
    VOP_MODE  = 3'd4,
    VOP_SEEK  = 3'd5,
    VOP_ADV   = 3'd6
  } pvm_vop_t;

  typedef enum logic [3:0] {
    RES_HOLD  = 4'd0,
    RES_TICK  = 4'd1,
    RES_OK    = 4'd2,
    RES_SLOT  = 4'd3,
    RES_ALLOC = 4'd4,
    RES_FAIL  = 4'd5,
    RES_VFAIL = 4'd6,
    RES_FREE  = 4'd7,
    RES_VSLOT = 4'd8,
    RES_VMODE = 4'd9,
    RES_SEEK  = 4'd10
  } pvm_res_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_DECODE = 4'd1,
    ST_WRITE  = 4'd2,
    ST_SLOT   = 4'd3,
    ST_ALLOC  = 4'd4,
    ST_VEXEC  = 4'd5,
    ST_SEEK   = 4'd6,
    ST_TREAD  = 4'd7,
    ST_TVOICE = 4'd8,
    ST_TSLOT  = 4'd9,
    ST_TADDR  = 4'd10,
    ST_TMIX   = 4'd11,
    ST_DONE   = 4'd12
  } pvm_state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  voice;
    logic [5:0]  slot;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
    logic [15:0] sample_base;
    logic [16:0] sample_length;
    logic [1:0]  new_state;
    logic [15:0] seek_position;
  } pvm_in_t;

  typedef struct packed {
    logic [7:0] mixed_sample;
    logic [4:0] voice_index;
    logic       ok;
    logic [1:0] voice_status;
  } pvm_out_t;

  typedef struct packed {
    pvm_mode_t   mode;
    logic [5:0]  slot;
    logic [15:0] pos;
  } pvm_voice_t;

  typedef struct packed {
    logic [15:0] base;
    logic [16:0] len;
  } pvm_slot_t;

  typedef struct packed {
    logic     latch;
    logic     voice_rd;
    logic     vsel_cnt;
    pvm_vop_t voice_op;
    logic     slot_rd;
    logic     slot_wr;
    logic     mem_wr;
    logic     mem_rd;
    logic     calc_sum;
    logic     acc_init;
    logic     acc_mix;
    logic     cnt_clr;
    logic     cnt_inc;
    pvm_res_t res_sel;
    logic     out_load;
  } pvm_ctl_t;

  typedef struct packed {
    pvm_op_t op;
    logic    voice_ok;
    logic    slot_ok;
    logic    vvalid;
    logic    vplay;
    logic    len_zero;
    logic    cnt_last;
    logic    cnt_used;
  } pvm_sts_t;

endpackage

[hw/rtl/pvm_ram.sv]
// ----------------------------------------------------------------------------
// PCM voice mixer generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module pvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/pvm_ctrl.sv]
// ----------------------------------------------------------------------------
// PCM voice mixer controller
// State machine that sequences each command through the datapath and owns
// the transaction handshakes on both channels.
// ----------------------------------------------------------------------------
module pvm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pvm_pkg::pvm_sts_t sts,
  output pvm_pkg::pvm_ctl_t ctl
);

  pvm_pkg::pvm_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != pvm_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pvm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pvm_pkg::ST_DECODE;
        end
      end
      pvm_pkg::ST_DECODE: begin
        case (sts.op)
          pvm_pkg::OP_TICK:  state_nxt = pvm_pkg::ST_TREAD;
          pvm_pkg::OP_WRITE: state_nxt = pvm_pkg::ST_WRITE;
          pvm_pkg::OP_SLOT:  state_nxt = pvm_pkg::ST_SLOT;
          pvm_pkg::OP_ALLOC: state_nxt = pvm_pkg::ST_ALLOC;
          default: begin
            state_nxt = sts.voice_ok ? pvm_pkg::ST_VEXEC : pvm_pkg::ST_DONE;
          end
        endcase
      end
      pvm_pkg::ST_WRITE, pvm_pkg::ST_SLOT, pvm_pkg::ST_SEEK: begin
        state_nxt = pvm_pkg::ST_DONE;
      end
      pvm_pkg::ST_ALLOC: begin
        if (!sts.cnt_used || sts.cnt_last) begin
          state_nxt = pvm_pkg::ST_DONE;
        end
      end
      pvm_pkg::ST_VEXEC: begin
        if (sts.vvalid && sts.op == pvm_pkg::OP_SEEK) begin
          state_nxt = pvm_pkg::ST_SEEK;
        end else begin
          state_nxt = pvm_pkg::ST_DONE;
        end
      end
      pvm_pkg::ST_TREAD: begin
        state_nxt = pvm_pkg::ST_TVOICE;
      end
      pvm_pkg::ST_TVOICE: begin
        if (sts.vplay) begin
          state_nxt = pvm_pkg::ST_TSLOT;
        end else begin
          state_nxt = sts.cnt_last ? pvm_pkg::ST_DONE : pvm_pkg::ST_TREAD;
        end
      end
      pvm_pkg::ST_TSLOT: begin
        if (!sts.len_zero) begin
          state_nxt = pvm_pkg::ST_TADDR;
        end else begin
          state_nxt = sts.cnt_last ? pvm_pkg::ST_DONE : pvm_pkg::ST_TREAD;
        end
      end
      pvm_pkg::ST_TADDR: begin
        state_nxt = pvm_pkg::ST_TMIX;
      end
      pvm_pkg::ST_TMIX: begin
        state_nxt = sts.cnt_last ? pvm_pkg::ST_DONE : pvm_pkg::ST_TREAD;
      end
      pvm_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = pvm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pvm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      pvm_pkg::ST_IDLE: begin
        ctl.latch = in_valid;
      end
      pvm_pkg::ST_DECODE: begin
        case (sts.op)
          pvm_pkg::OP_TICK: begin
            ctl.cnt_clr  = 1'b1;
            ctl.acc_init = 1'b1;
          end
          pvm_pkg::OP_ALLOC: begin
            ctl.cnt_clr = 1'b1;
          end
          pvm_pkg::OP_FREE, pvm_pkg::OP_VSLOT, pvm_pkg::OP_STATE, pvm_pkg::OP_SEEK: begin
            if (sts.voice_ok) begin
              ctl.voice_rd = 1'b1;
            end else begin
              ctl.res_sel = pvm_pkg::RES_VFAIL;
            end
          end
          default: begin
          end
        endcase
      end
      pvm_pkg::ST_WRITE: begin
        ctl.mem_wr  = 1'b1;
        ctl.res_sel = pvm_pkg::RES_OK;
      end
      pvm_pkg::ST_SLOT: begin
        ctl.slot_wr = sts.slot_ok;
        ctl.res_sel = pvm_pkg::RES_SLOT;
      end
      pvm_pkg::ST_ALLOC: begin
        ctl.vsel_cnt = 1'b1;
        if (!sts.cnt_used) begin
          ctl.voice_op = pvm_pkg::VOP_ALLOC;
          ctl.res_sel  = pvm_pkg::RES_ALLOC;
        end else if (sts.cnt_last) begin
          ctl.res_sel = pvm_pkg::RES_FAIL;
        end else begin
          ctl.cnt_inc = 1'b1;
        end
      end
      pvm_pkg::ST_VEXEC: begin
        if (!sts.vvalid) begin
          ctl.res_sel = pvm_pkg::RES_VFAIL;
        end else begin
          case (sts.op)
            pvm_pkg::OP_FREE: begin
              ctl.voice_op = pvm_pkg::VOP_FREE;
              ctl.res_sel  = pvm_pkg::RES_FREE;
            end
            pvm_pkg::OP_VSLOT: begin
              ctl.voice_op = sts.slot_ok ? pvm_pkg::VOP_SLOT : pvm_pkg::VOP_NONE;
              ctl.res_sel  = pvm_pkg::RES_VSLOT;
            end
            pvm_pkg::OP_STATE: begin
              ctl.voice_op = pvm_pkg::VOP_MODE;
              ctl.res_sel  = pvm_pkg::RES_VMODE;
            end
            pvm_pkg::OP_SEEK: begin
              ctl.slot_rd = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      pvm_pkg::ST_SEEK: begin
        ctl.voice_op = sts.len_zero ? pvm_pkg::VOP_NONE : pvm_pkg::VOP_SEEK;
        ctl.res_sel  = pvm_pkg::RES_SEEK;
      end
      pvm_pkg::ST_TREAD: begin
        ctl.voice_rd = 1'b1;
        ctl.vsel_cnt = 1'b1;
      end
      pvm_pkg::ST_TVOICE: begin
        ctl.vsel_cnt = 1'b1;
        if (sts.vplay) begin
          ctl.slot_rd = 1'b1;
        end else if (sts.cnt_last) begin
          ctl.res_sel = pvm_pkg::RES_TICK;
        end else begin
          ctl.cnt_inc = 1'b1;
        end
      end
      pvm_pkg::ST_TSLOT: begin
        ctl.vsel_cnt = 1'b1;
        if (!sts.len_zero) begin
          ctl.calc_sum = 1'b1;
        end else if (sts.cnt_last) begin
          ctl.res_sel = pvm_pkg::RES_TICK;
        end else begin
          ctl.cnt_inc = 1'b1;
        end
      end
      pvm_pkg::ST_TADDR: begin
        ctl.vsel_cnt = 1'b1;
        ctl.mem_rd   = 1'b1;
      end
      pvm_pkg::ST_TMIX: begin
        ctl.vsel_cnt = 1'b1;
        ctl.acc_mix  = 1'b1;
        ctl.voice_op = pvm_pkg::VOP_ADV;
        if (sts.cnt_last) begin
          ctl.res_sel = pvm_pkg::RES_TICK;
        end else begin
          ctl.cnt_inc = 1'b1;
        end
      end
      pvm_pkg::ST_DONE: begin
        ctl.out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pvm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/pvm_dp.sv]
// ----------------------------------------------------------------------------
// PCM voice mixer datapath
// Sample memory, slot and voice memories with their valid bits, the mix
// accumulator, address wrap logic and the result registers.
// ----------------------------------------------------------------------------
module pvm_dp #(
  parameter int NUM_VOICES = 32,
  parameter int NUM_SLOTS  = 64,
  parameter int MEM_DEPTH  = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pvm_pkg::pvm_in_t  in_data,
  input  pvm_pkg::pvm_ctl_t ctl,
  output pvm_pkg::pvm_sts_t sts,
  output pvm_pkg::pvm_out_t out_data
);

  localparam int VAW        = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int SAW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MAW        = $clog2(MEM_DEPTH);
  localparam int SUM_W      = pvm_pkg::SUM_W;
  localparam int QMAX       = ((2 ** SUM_W) - 1) / MEM_DEPTH;
  localparam int WRAP_STEPS = (QMAX == 0) ? 0 : $clog2(QMAX + 1);
  localparam int VREC_W     = $bits(pvm_pkg::pvm_voice_t);
  localparam int SREC_W     = $bits(pvm_pkg::pvm_slot_t);

  // Remainder by the memory depth through a short restoring chain.
  function automatic logic [MAW-1:0] wrap_addr(input logic [SUM_W-1:0] x);
    logic [31:0] r;
    r = 32'(x);
    for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
      if (r >= (32'(MEM_DEPTH) << k)) begin
        r = r - (32'(MEM_DEPTH) << k);
      end
    end
    return r[MAW-1:0];
  endfunction

  pvm_pkg::pvm_in_t    item_r, item_nxt;
  logic [VAW-1:0]      cnt_r, cnt_nxt;
  logic [NUM_VOICES-1:0] vvalid_r, vvalid_nxt;
  logic [NUM_SLOTS-1:0]  svalid_r, svalid_nxt;
  logic                vq_valid_r, vq_valid_nxt;
  logic                sq_valid_r, sq_valid_nxt;
  logic [7:0]          acc_r, acc_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [15:0]         posf_r, posf_nxt;
  logic [16:0]         len_r, len_nxt;
  pvm_pkg::pvm_out_t   res_r, res_nxt;
  pvm_pkg::pvm_out_t   out_r, out_nxt;

  pvm_pkg::pvm_op_t    op;
  logic [6:0]          vf_ext, cnt_ext;
  logic [VAW-1:0]      vf_idx, vaddr;
  logic [8:0]          sf_ext, vs_ext;
  logic [SAW-1:0]      sf_idx, vs_idx;
  logic                voice_ok, slot_ok;
  logic [VREC_W-1:0]   vram_q, vram_wdata;
  logic                vram_we;
  pvm_pkg::pvm_voice_t vcur, vwr;
  logic [SREC_W-1:0]   sram_q, sram_wdata;
  pvm_pkg::pvm_slot_t  scur, swr;
  logic [7:0]          mram_q;
  logic [MAW-1:0]      mem_waddr, mem_raddr;
  pvm_pkg::pvm_mode_t  mode_sel, mode_adv;
  logic [16:0]         len_sat, pos_inc;
  logic [15:0]         pos_fix, pos_new, seek_pos;

  assign op       = pvm_pkg::pvm_op_t'(item_r.cmd);
  assign vf_ext   = 7'(item_r.voice);
  assign voice_ok = (vf_ext < 7'(NUM_VOICES));
  assign vf_idx   = vf_ext[VAW-1:0];
  assign cnt_ext  = 7'(cnt_r);
  assign sf_ext   = 9'(item_r.slot);
  assign slot_ok  = (sf_ext < 9'(NUM_SLOTS));
  assign sf_idx   = sf_ext[SAW-1:0];
  assign vaddr    = ctl.vsel_cnt ? cnt_r : vf_idx;

  assign vcur   = vq_valid_r ? pvm_pkg::pvm_voice_t'(vram_q) : '0;
  assign scur   = sq_valid_r ? pvm_pkg::pvm_slot_t'(sram_q) : '0;
  assign vs_ext = 9'(vcur.slot);
  assign vs_idx = vs_ext[SAW-1:0];

  assign len_sat  = (item_r.sample_length > pvm_pkg::MAX_LEN) ? pvm_pkg::MAX_LEN
                                                               : item_r.sample_length;
  assign pos_fix  = ({1'b0, vcur.pos} >= scur.len) ? 16'd0 : vcur.pos;
  assign pos_inc  = {1'b0, posf_r} + 17'd1;
  assign pos_new  = (pos_inc == len_r) ? 16'd0 : pos_inc[15:0];
  assign mode_adv = (pos_new == 16'd0 && vcur.mode == pvm_pkg::MODE_ONCE) ?
                    pvm_pkg::MODE_PAUSED : vcur.mode;
  assign seek_pos = ({1'b0, item_r.seek_position} < scur.len) ? item_r.seek_position
                                                               : 16'(scur.len - 17'd1);

  assign mem_waddr = wrap_addr(SUM_W'(item_r.mem_addr));
  assign mem_raddr = wrap_addr(sum_r);

  always_comb begin
    case (item_r.new_state)
      pvm_pkg::NST_ONCE: mode_sel = pvm_pkg::MODE_ONCE;
      pvm_pkg::NST_LOOP: mode_sel = pvm_pkg::MODE_LOOP;
      default:           mode_sel = pvm_pkg::MODE_PAUSED;
    endcase
  end

  always_comb begin
    vwr        = vcur;
    vram_we    = 1'b0;
    vvalid_nxt = vvalid_r;
    case (ctl.voice_op)
      pvm_pkg::VOP_ALLOC: begin
        vwr.mode          = pvm_pkg::MODE_PAUSED;
        vwr.slot          = 6'd0;
        vwr.pos           = 16'd0;
        vram_we           = 1'b1;
        vvalid_nxt[vaddr] = 1'b1;
      end
      pvm_pkg::VOP_FREE: begin
        vvalid_nxt[vaddr] = 1'b0;
      end
      pvm_pkg::VOP_SLOT: begin
        vwr.slot = item_r.slot;
        vwr.pos  = 16'd0;
        vram_we  = 1'b1;
      end
      pvm_pkg::VOP_MODE: begin
        vwr.mode = mode_sel;
        vram_we  = 1'b1;
      end
      pvm_pkg::VOP_SEEK: begin
        vwr.pos = seek_pos;
        vram_we = 1'b1;
      end
      pvm_pkg::VOP_ADV: begin
        vwr.pos  = pos_new;
        vwr.mode = mode_adv;
        vram_we  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign vram_wdata = vwr;

  always_comb begin
    swr.base   = item_r.sample_base;
    swr.len    = len_sat;
    svalid_nxt = svalid_r;
    if (ctl.slot_wr) begin
      svalid_nxt[sf_idx] = 1'b1;
    end
  end

  assign sram_wdata = swr;

  always_comb begin
    item_nxt     = ctl.latch ? in_data : item_r;
    vq_valid_nxt = ctl.voice_rd ? vvalid_r[vaddr] : vq_valid_r;
    sq_valid_nxt = ctl.slot_rd ? svalid_r[vs_idx] : sq_valid_r;

    if (ctl.cnt_clr) begin
      cnt_nxt = '0;
    end else if (ctl.cnt_inc) begin
      cnt_nxt = cnt_r + VAW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end

    if (ctl.acc_init) begin
      acc_nxt = pvm_pkg::MIX_START;
    end else if (ctl.acc_mix) begin
      acc_nxt = 8'(({1'b0, acc_r} + {1'b0, mram_q}) >> 1);
    end else begin
      acc_nxt = acc_r;
    end

    if (ctl.calc_sum) begin
      sum_nxt  = SUM_W'(scur.base) + SUM_W'(pos_fix);
      posf_nxt = pos_fix;
      len_nxt  = scur.len;
    end else begin
      sum_nxt  = sum_r;
      posf_nxt = posf_r;
      len_nxt  = len_r;
    end
  end

  always_comb begin
    res_nxt = '0;
    case (ctl.res_sel)
      pvm_pkg::RES_HOLD: begin
        res_nxt = res_r;
      end
      pvm_pkg::RES_TICK: begin
        res_nxt.mixed_sample = acc_nxt;
        res_nxt.ok           = 1'b1;
      end
      pvm_pkg::RES_OK: begin
        res_nxt.ok = 1'b1;
      end
      pvm_pkg::RES_SLOT: begin
        res_nxt.ok = slot_ok;
      end
      pvm_pkg::RES_ALLOC: begin
        res_nxt.voice_index  = cnt_ext[4:0];
        res_nxt.ok           = 1'b1;
        res_nxt.voice_status = pvm_pkg::MODE_PAUSED;
      end
      pvm_pkg::RES_FAIL: begin
      end
      pvm_pkg::RES_VFAIL: begin
        res_nxt.voice_index = item_r.voice;
      end
      pvm_pkg::RES_FREE: begin
        res_nxt.voice_index  = item_r.voice;
        res_nxt.ok           = 1'b1;
        res_nxt.voice_status = pvm_pkg::MODE_UNUSED;
      end
      pvm_pkg::RES_VSLOT: begin
        res_nxt.voice_index  = item_r.voice;
        res_nxt.ok           = slot_ok;
        res_nxt.voice_status = vcur.mode;
      end
      pvm_pkg::RES_VMODE: begin
        res_nxt.voice_index  = item_r.voice;
        res_nxt.ok           = 1'b1;
        res_nxt.voice_status = mode_sel;
      end
      pvm_pkg::RES_SEEK: begin
        res_nxt.voice_index  = item_r.voice;
        res_nxt.ok           = (scur.len != 17'd0);
        res_nxt.voice_status = vcur.mode;
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  assign out_nxt  = ctl.out_load ? res_r : out_r;
  assign out_data = out_r;

  always_comb begin
    sts.op       = op;
    sts.voice_ok = voice_ok;
    sts.slot_ok  = slot_ok;
    sts.vvalid   = vq_valid_r;
    sts.vplay    = vq_valid_r &&
                   (vcur.mode == pvm_pkg::MODE_ONCE || vcur.mode == pvm_pkg::MODE_LOOP);
    sts.len_zero = (scur.len == 17'd0);
    sts.cnt_last = (cnt_r == VAW'(NUM_VOICES - 1));
    sts.cnt_used = vvalid_r[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      vvalid_r   <= '0;
      svalid_r   <= '0;
      vq_valid_r <= 1'b0;
      sq_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      vvalid_r   <= vvalid_nxt;
      svalid_r   <= svalid_nxt;
      vq_valid_r <= vq_valid_nxt;
      sq_valid_r <= sq_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    acc_r  <= acc_nxt;
    sum_r  <= sum_nxt;
    posf_r <= posf_nxt;
    len_r  <= len_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  pvm_ram #(
    .WIDTH(VREC_W),
    .DEPTH(NUM_VOICES)
  ) u_voice_ram (
    .clk    (clk),
    .wr_en  (vram_we),
    .wr_addr(vaddr),
    .wr_data(vram_wdata),
    .rd_en  (ctl.voice_rd),
    .rd_addr(vaddr),
    .rd_data(vram_q)
  );

  pvm_ram #(
    .WIDTH(SREC_W),
    .DEPTH(NUM_SLOTS)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (ctl.slot_wr),
    .wr_addr(sf_idx),
    .wr_data(sram_wdata),
    .rd_en  (ctl.slot_rd),
    .rd_addr(vs_idx),
    .rd_data(sram_q)
  );

  pvm_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_sample_ram (
    .clk    (clk),
    .wr_en  (ctl.mem_wr),
    .wr_addr(mem_waddr),
    .wr_data(item_r.mem_data),
    .rd_en  (ctl.mem_rd),
    .rd_addr(mem_raddr),
    .rd_data(mram_q)
  );

endmodule

[hw/rtl/pcm_voice_mixer_core.sv]
// ----------------------------------------------------------------------------
// PCM voice mixer core
// An 8-bit PCM sample player with NUM_VOICES voices and NUM_SLOTS sample
// slots over a MEM_DEPTH byte sample memory. Each command transaction
// returns exactly one result transaction, and one command is processed at a
// time. A tick walks the voices in order through the voice, slot and sample
// memories: it reads each voice record, the slot record of each playing
// voice and one sample byte for each voice that plays a non-empty slot. An
// allocate scans the voices in order up to the first free one. A finished
// result waits in an output register, so the next command is accepted while
// the previous result is still stalled. The slot and voice tables read as
// empty after reset with no clearing pass; sample memory holds no defined
// data until it is written.
// ----------------------------------------------------------------------------
module pcm_voice_mixer_core #(
  parameter int NUM_VOICES = 32,
  parameter int NUM_SLOTS  = 64,
  parameter int MEM_DEPTH  = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pvm_pkg::pvm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pvm_pkg::pvm_out_t out_data
);

  pvm_pkg::pvm_ctl_t ctl;
  pvm_pkg::pvm_sts_t sts;

  pvm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  pvm_dp #(
    .NUM_VOICES(NUM_VOICES),
    .NUM_SLOTS (NUM_SLOTS),
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .ctl     (ctl),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule

[sim/pcm_voice_mixer_core_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM voice mixer result checker
// Watches the command and result channels of the mixer core. Every accepted
// command is run through a local copy of the sample memory, slot table and
// voice table to predict its result, and every accepted result is compared
// field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module pcm_voice_mixer_core_chk
  import pvm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  pvm_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  pvm_out_t out_data,
  output int       errors,
  output int       outstanding,
  output int       results_seen,
  output int       voiced_ticks,
  output int       alloc_refused
);

  localparam int NVOICE = 32;
  localparam int NSLOT  = 64;
  localparam int MEMSZ  = 65536;

  typedef struct packed {
    pvm_op_t  op;
    pvm_out_t res;
  } due_t;

  logic [7:0]  pcm_mem   [MEMSZ];
  logic [15:0] slot_base [NSLOT];
  logic [16:0] slot_len  [NSLOT];
  pvm_mode_t   vc_mode   [NVOICE];
  logic [5:0]  vc_slot   [NVOICE];
  logic [15:0] vc_pos    [NVOICE];
  due_t        due_q[$];
  int          reported;

  function automatic pvm_out_t mix_step(pvm_in_t c);
    pvm_out_t r;
    int       acc;
    int       len;
    int       pos;
    int       s;
    int       v;
    logic     hit;
    logic     found;
    r = '0;
    case (pvm_op_t'(c.cmd))
      OP_TICK: begin
        acc = MIX_START;
        hit = 1'b0;
        for (v = 0; v < NVOICE; v++) begin
          s = vc_slot[v];
          len = slot_len[s];
          if ((vc_mode[v] == MODE_ONCE || vc_mode[v] == MODE_LOOP) && len != 0) begin
            pos = vc_pos[v];
            if (pos >= len) begin
              pos = 0;
            end
            acc = (acc + pcm_mem[(slot_base[s] + pos) % MEMSZ]) >> 1;
            pos = (pos + 1) % len;
            vc_pos[v] = 16'(pos);
            if (pos == 0 && vc_mode[v] == MODE_ONCE) begin
              vc_mode[v] = MODE_PAUSED;
            end
            hit = 1'b1;
          end
        end
        if (hit) begin
          voiced_ticks++;
        end
        r.mixed_sample = 8'(acc);
        r.ok = 1'b1;
      end
      OP_WRITE: begin
        pcm_mem[c.mem_addr] = c.mem_data;
        r.ok = 1'b1;
      end
      OP_SLOT: begin
        slot_base[c.slot] = c.sample_base;
        slot_len[c.slot] = (c.sample_length > MAX_LEN) ? MAX_LEN : c.sample_length;
        r.ok = 1'b1;
      end
      OP_ALLOC: begin
        found = 1'b0;
        for (v = 0; v < NVOICE; v++) begin
          if (!found && vc_mode[v] == MODE_UNUSED) begin
            found = 1'b1;
            vc_mode[v] = MODE_PAUSED;
            vc_slot[v] = '0;
            vc_pos[v] = '0;
            r.voice_index = 5'(v);
            r.ok = 1'b1;
            r.voice_status = MODE_PAUSED;
          end
        end
        if (!found) begin
          alloc_refused++;
        end
      end
      default: begin
        r.voice_index = c.voice;
        if (vc_mode[c.voice] != MODE_UNUSED) begin
          case (pvm_op_t'(c.cmd))
            OP_FREE: begin
              vc_mode[c.voice] = MODE_UNUSED;
              vc_slot[c.voice] = '0;
              vc_pos[c.voice] = '0;
              r.ok = 1'b1;
            end
            OP_VSLOT: begin
              vc_slot[c.voice] = c.slot;
              vc_pos[c.voice] = '0;
              r.ok = 1'b1;
            end
            OP_STATE: begin
              if (c.new_state == NST_ONCE) begin
                vc_mode[c.voice] = MODE_ONCE;
              end else if (c.new_state == NST_LOOP) begin
                vc_mode[c.voice] = MODE_LOOP;
              end else begin
                vc_mode[c.voice] = MODE_PAUSED;
              end
              r.ok = 1'b1;
            end
            default: begin
              len = slot_len[vc_slot[c.voice]];
              if (len != 0) begin
                vc_pos[c.voice] = (c.seek_position < len) ? c.seek_position : 16'(len - 1);
                r.ok = 1'b1;
              end
            end
          endcase
        end
        r.voice_status = vc_mode[c.voice];
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    due_t d;
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        slot_base[i] = '0;
        slot_len[i] = '0;
      end
      for (int i = 0; i < NVOICE; i++) begin
        vc_mode[i] = MODE_UNUSED;
        vc_slot[i] = '0;
        vc_pos[i] = '0;
      end
      due_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        d.op = pvm_op_t'(in_data.cmd);
        d.res = mix_step(in_data);
        due_q.push_back(d);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_q.size() == 0) begin
          errors++;
          if (reported < 10) begin
            $display("%0t: result with no command pending: mix=%0d idx=%0d ok=%0d st=%0d",
                     $realtime, out_data.mixed_sample, out_data.voice_index, out_data.ok,
                     out_data.voice_status);
            reported++;
          end
        end else begin
          d = due_q.pop_front();
          if (out_data.mixed_sample !== d.res.mixed_sample ||
              out_data.voice_index !== d.res.voice_index ||
              out_data.ok !== d.res.ok ||
              out_data.voice_status !== d.res.voice_status) begin
            errors++;
            if (reported < 10) begin
              $display("%0t: %s mismatch: expected mix=%0d idx=%0d ok=%0d st=%0d",
                       $realtime, d.op.name(), d.res.mixed_sample, d.res.voice_index,
                       d.res.ok, d.res.voice_status);
              $display("%0t: %s mismatch: actual   mix=%0d idx=%0d ok=%0d st=%0d",
                       $realtime, d.op.name(), out_data.mixed_sample, out_data.voice_index,
                       out_data.ok, out_data.voice_status);
              reported++;
            end
          end
        end
      end
    end
    outstanding = due_q.size();
  end

endmodule

[sim/pcm_voice_mixer_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM voice mixer core testbench
// Drives directed and random command transactions into the mixer core with
// random gaps on both channels, keeps every playable slot inside sample
// memory that has been written, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module pcm_voice_mixer_core_tb;
  import pvm_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int RUN_ITEMS   = 1600;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  pvm_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pvm_out_t out_data;

  int          errors;
  int          outstanding;
  int          results_seen;
  int          voiced_ticks;
  int          alloc_refused;
  int          sent;
  int          quiet;
  bit          gaps;
  bit          slot_clean [64];
  logic [5:0]  bound      [32];
  logic [15:0] burst_base;
  int          burst_len;

  pcm_voice_mixer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  pcm_voice_mixer_core_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .errors        (errors),
    .outstanding   (outstanding),
    .results_seen  (results_seen),
    .voiced_ticks  (voiced_ticks),
    .alloc_refused (alloc_refused)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= gaps && ($urandom_range(0, 99) < 32);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("[pcm_voice_mixer_core] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic pvm_in_t any_cmd(pvm_op_t op);
    pvm_in_t c;
    c.cmd           = op;
    c.voice         = 5'($urandom_range(0, 31));
    c.slot          = 6'($urandom_range(0, 63));
    c.mem_addr      = 16'($urandom_range(0, 65535));
    c.mem_data      = 8'($urandom_range(0, 255));
    c.sample_base   = 16'($urandom_range(0, 65535));
    c.sample_length = 17'($urandom_range(0, 131071));
    c.new_state     = 2'($urandom_range(0, 3));
    c.seek_position = 16'($urandom_range(0, 65535));
    return c;
  endfunction

  // A slot marked unclean may point at unwritten memory, so no voice may be
  // bound to it while it stays that way.
  task automatic issue(input pvm_in_t c, input bit risky = 1'b0);
    if (pvm_op_t'(c.cmd) == OP_SLOT) begin
      slot_clean[c.slot] = !risky || c.sample_length == 0;
    end
    if (pvm_op_t'(c.cmd) == OP_VSLOT) begin
      bound[c.voice] = c.slot;
    end
    @(negedge clk);
    while (gaps && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  initial begin
    pvm_in_t     c;
    int          i;
    int          n;
    int          v;
    int          s;
    int          blen;
    int          pick;
    logic [15:0] bbase;
    bit          risky;
    bit          busy;
    bit          held;

    gaps = 1'b1;
    held = 1'b0;
    burst_len = 0;
    burst_base = '0;
    for (i = 0; i < 64; i++) slot_clean[i] = 1'b1;
    for (i = 0; i < 32; i++) bound[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue(any_cmd(OP_TICK));
    c = any_cmd(OP_WRITE); c.mem_addr = 16'hFFFF; c.mem_data = 8'hFF; issue(c);
    c = any_cmd(OP_WRITE); c.mem_addr = 16'h0000; c.mem_data = 8'h00; issue(c);
    c = any_cmd(OP_WRITE); c.mem_addr = 16'h0001; c.mem_data = 8'h80; issue(c);
    c = any_cmd(OP_SLOT); c.slot = 6'd1; c.sample_base = 16'hFFFF; c.sample_length = 17'd3;
    issue(c);
    c = any_cmd(OP_SLOT); c.slot = 6'd2; c.sample_length = 17'h1FFFF; issue(c, 1'b1);
    c = any_cmd(OP_SLOT); c.slot = 6'd3; c.sample_base = '0; c.sample_length = MAX_LEN;
    issue(c, 1'b1);
    issue(any_cmd(OP_ALLOC));
    c = any_cmd(OP_SEEK); c.voice = 5'd0; issue(c);
    c = any_cmd(OP_VSLOT); c.voice = 5'd0; c.slot = 6'd1; issue(c);
    c = any_cmd(OP_STATE); c.voice = 5'd0; c.new_state = NST_ONCE; issue(c);
    c = any_cmd(OP_SEEK); c.voice = 5'd0; c.seek_position = 16'hFFFF; issue(c);
    issue(any_cmd(OP_TICK));
    issue(any_cmd(OP_TICK));
    c = any_cmd(OP_STATE); c.voice = 5'd0; c.new_state = 2'd3; issue(c);
    c = any_cmd(OP_STATE); c.voice = 5'd0; c.new_state = 2'd0; issue(c);
    c = any_cmd(OP_STATE); c.voice = 5'd0; c.new_state = NST_LOOP; issue(c);
    c = any_cmd(OP_SEEK); c.voice = 5'd0; c.seek_position = 16'd1; issue(c);
    c = any_cmd(OP_SLOT); c.slot = 6'd1; c.sample_base = 16'hFFFF; c.sample_length = 17'd1;
    issue(c);
    issue(any_cmd(OP_TICK));
    c = any_cmd(OP_FREE); c.voice = 5'd0; issue(c);
    c = any_cmd(OP_FREE); c.voice = 5'd0; issue(c);
    c = any_cmd(OP_VSLOT); c.voice = 5'd9; c.slot = 6'd1; issue(c);
    c = any_cmd(OP_SEEK); c.voice = 5'd31; issue(c);
    c = any_cmd(OP_STATE); c.voice = 5'd17; issue(c);
    c = any_cmd(OP_SLOT); c.slot = 6'd4; c.sample_length = '0; issue(c);
    burst_base = 16'hFFFF;
    burst_len = 3;

    while (sent < RUN_ITEMS) begin
      gaps = !(sent >= 700 && sent < 1000);
      if (!held && sent >= 500) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        held = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        blen = $urandom_range(1, 12);
        if ($urandom_range(0, 3) == 0) begin
          bbase = 16'hFFFF - 16'($urandom_range(0, 6));
        end else begin
          bbase = 16'($urandom_range(0, 65535));
        end
        for (i = 0; i < blen; i++) begin
          c = any_cmd(OP_WRITE); c.mem_addr = bbase + 16'(i); issue(c);
        end
        burst_base = bbase;
        burst_len = blen;
        s = $urandom_range(0, 63);
        c = any_cmd(OP_SLOT); c.slot = 6'(s); c.sample_base = bbase;
        c.sample_length = 17'($urandom_range(1, blen));
        issue(c);
        if ($urandom_range(0, 2) == 0) begin
          issue(any_cmd(OP_ALLOC));
        end
        v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 5);
        c = any_cmd(OP_VSLOT); c.voice = 5'(v); c.slot = 6'(s); issue(c);
        c = any_cmd(OP_STATE); c.voice = 5'(v);
        c.new_state = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(0, 3))
                                                  : 2'($urandom_range(1, 2));
        issue(c);
        if ($urandom_range(0, 1) == 0) begin
          c = any_cmd(OP_SEEK); c.voice = 5'(v);
          if ($urandom_range(0, 1) == 0) c.seek_position = 16'($urandom_range(0, 15));
          issue(c);
        end
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) issue(any_cmd(OP_TICK));
        if ($urandom_range(0, 3) == 0) begin
          c = any_cmd(OP_SLOT); c.slot = 6'(s); c.sample_base = bbase;
          c.sample_length = 17'($urandom_range(1, blen));
          issue(c);
          issue(any_cmd(OP_TICK));
          issue(any_cmd(OP_TICK));
        end
        if ($urandom_range(0, 4) == 0) begin
          c = any_cmd(OP_FREE); c.voice = 5'(v); issue(c);
        end
      end else if (pick < 58) begin
        for (i = 0; i < 33; i++) issue(any_cmd(OP_ALLOC));
        for (i = 0; i < 8; i++) issue(any_cmd(OP_FREE));
      end else begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) begin
          c = any_cmd(pvm_op_t'($urandom_range(0, 7)));
          risky = 1'b0;
          if (pvm_op_t'(c.cmd) == OP_SLOT) begin
            busy = 1'b0;
            for (v = 0; v < 32; v++) begin
              if (bound[v] == c.slot) busy = 1'b1;
            end
            if (c.slot != 0 && !busy && $urandom_range(0, 1) == 0) begin
              risky = 1'b1;
            end else if ($urandom_range(0, 1) == 0 || burst_len == 0) begin
              c.sample_length = '0;
            end else begin
              c.sample_base = burst_base;
              c.sample_length = 17'($urandom_range(1, burst_len));
            end
          end
          if (pvm_op_t'(c.cmd) == OP_VSLOT && !slot_clean[c.slot]) begin
            c.slot = '0;
          end
          issue(c, risky);
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (300) @(posedge clk);
    $display("Run covered %0d commands and %0d checked results; %0d ticks mixed voices,",
             sent, results_seen, voiced_ticks);
    $display("and %0d allocations were refused with every voice taken.", alloc_refused);
    if (errors == 0 && outstanding == 0) begin
      $display("[pcm_voice_mixer_core] OK");
    end else begin
      $display("[pcm_voice_mixer_core] ERROR");
    end
    $finish;
  end

endmodule
